// ===== sv/sdspi_pkg.sv =====
// Shared definitions for the SD card SPI-mode command responder.
// Holds opcodes, command numbers, R1 and status codes, and the CRC7 helpers.
// Used by sd_spi_command_responder; depends on nothing else.
package sdspi_pkg;

	// Block addressing.
	localparam int BLOCK_ADDR_WIDTH = 32;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << BLOCK_ADDR_WIDTH) - 64'd1);

	// Input opcodes, carried on the input tuser.
	localparam logic [1:0] OP_COMMAND   = 2'd0;
	localparam logic [1:0] OP_DATA_SLOT = 2'd1;
	localparam logic [1:0] OP_READ_FAIL = 2'd2;

	// Result kinds, carried on the output tuser.
	localparam logic [1:0] KIND_BYTE     = 2'd0;
	localparam logic [1:0] KIND_FETCH    = 2'd1;
	localparam logic [1:0] KIND_SEND_CID = 2'd2;
	localparam logic [1:0] KIND_SEND_CSD = 2'd3;

	// Transfer mode of the card.
	typedef enum logic [1:0] {
		XFER_IDLE  = 2'd0,
		XFER_CID   = 2'd1,
		XFER_CSD   = 2'd2,
		XFER_BLOCK = 2'd3
	} mode_t;

	// Command numbers.
	localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
	localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
	localparam logic [5:0] CMD_SEND_CID     = 6'd10;
	localparam logic [5:0] CMD_STOP         = 6'd12;
	localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
	localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
	localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
	localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
	localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
	localparam logic [5:0] CMD_ERASE_START  = 6'd32;
	localparam logic [5:0] CMD_ERASE_END    = 6'd33;
	localparam logic [5:0] CMD_ERASE        = 6'd38;
	localparam logic [5:0] CMD_APP_CMD      = 6'd55;
	localparam logic [5:0] CMD_READ_OCR     = 6'd58;
	localparam logic [5:0] CMD_CRC_ON_OFF   = 6'd59;
	localparam logic [5:0] ACMD_SET_WR_ERASE = 6'd23;
	localparam logic [5:0] ACMD_SEND_OP_COND = 6'd41;

	// R1 response codes.
	localparam logic [7:0] R1_READY     = 8'h00;
	localparam logic [7:0] R1_IDLE      = 8'h01;
	localparam logic [7:0] R1_ERASE_CLR = 8'h02;
	localparam logic [7:0] R1_ILLEGAL   = 8'h04;
	localparam logic [7:0] R1_CRC_ERR   = 8'h08;
	localparam logic [7:0] R1_PARAM_ERR = 8'h40;

	// Status byte codes.
	localparam logic [7:0] ST_READY        = 8'h00;
	localparam logic [7:0] ST_WRITE_PROT   = 8'h01;
	localparam logic [7:0] ST_ERROR        = 8'h04;
	localparam logic [7:0] ST_WP_VIOLATION = 8'h20;
	localparam logic [7:0] ST_OUT_OF_RANGE = 8'h80;

	// Fixed response bytes.
	localparam logic [7:0]  FILL_BYTE    = 8'hff;
	localparam logic [7:0]  IF_COND_BYTE = 8'hf0;
	localparam logic [31:0] OCR_VALUE    = 32'hffffff01;
	localparam logic [7:0]  START_BITS   = 8'h40;

	// Response line: up to seven bytes per command.
	localparam int RESP_MAX = 7;
	typedef logic [RESP_MAX-1:0][7:0] resp_bytes_t;

	// CRC7 over the 40-bit command frame body (start bits, index, argument).
	localparam int CRC_MSG_W = 40;
	typedef logic [CRC_MSG_W-1:0][6:0] crc7_cols_t;

	// Bit-serial reference form, used only to build the column table.
	function automatic logic [6:0] crc7_serial(input logic [CRC_MSG_W-1:0] msg);
		logic [6:0] crc;
		logic       fb;
		crc = 7'd0;
		for (int b = CRC_MSG_W - 1; b >= 0; b--) begin
			fb  = msg[b] ^ crc[6];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
		end
		return crc;
	endfunction

	// The CRC is linear, so each message bit contributes a fixed column.
	function automatic crc7_cols_t crc7_columns();
		crc7_cols_t cols;
		for (int i = 0; i < CRC_MSG_W; i++) begin
			cols[i] = crc7_serial(CRC_MSG_W'(1) << i);
		end
		return cols;
	endfunction

	localparam crc7_cols_t CRC7_COLS = crc7_columns();

	// Parallel form: XOR of the columns of the set bits.
	function automatic logic [6:0] crc7_parallel(input logic [CRC_MSG_W-1:0] msg);
		logic [6:0] crc;
		crc = 7'd0;
		for (int i = 0; i < CRC_MSG_W; i++) begin
			crc = crc ^ (CRC7_COLS[i] & {7{msg[i]}});
		end
		return crc;
	endfunction

endpackage

// ===== sv/sd_spi_command_responder.sv =====
// Card-side SD SPI-mode command responder for a read-only card, top level.
// Registers the input beat, decodes it in one pass and serializes the results.
// Depends on sdspi_pkg.

// Each input beat is one event: a checked command frame, a free data slot or
// a storage read failure. An input beat is taken into the input register in
// any cycle in which that register is empty or is being handed on, so beats
// may arrive back to back. The decode works combinationally on the input register
// and loads the result line: a command gives three to seven output beats (two
// 0xFF fillers, R1 and any extra bytes) or none if it is a bad frame during a
// transfer, a data slot at most one, a failure none. Output beats leave one per
// cycle while m_tready is high, and the next beat that has results waits for the
// last beat of the burst ahead of it; beats with no result pass the decode without
// waiting. The last output beat of each input carries tlast. block_capacity is written on the cfg
// channel, which is always ready, and must only be written while idle.
module sd_spi_command_responder (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: block_capacity.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command_index[5:0], argument[37:6], crc_byte[45:38], 0
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // data_byte[7:0], block_number[39:8]
	output logic [1:0]  m_tuser,  // kind[1:0]
	output logic        m_tlast
);

	// Configuration register.
	logic [31:0] block_capacity_q;

	// Input register.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [5:0]  cmd_s1;
	logic [31:0] arg_s1;
	logic [7:0]  crc_s1;

	// Card state.
	sdspi_pkg::mode_t mode_q, mode_d;
	logic [7:0]  status_q, status_d;
	logic        app_pend_q, app_pend_d;
	logic [31:0] blocks_rem_q, blocks_rem_d;
	logic [31:0] next_block_q, next_block_d;
	logic        crc_en_q, crc_en_d;
	logic        host_hc_q, host_hc_d;

	// Result line.
	logic [2:0]             rem_q;
	sdspi_pkg::resp_bytes_t bytes_q;
	logic [1:0]             kind_q;
	logic [31:0]            blk_q;

	// Decode results.
	logic [2:0]             res_n;
	sdspi_pkg::resp_bytes_t res_bytes;
	logic [1:0]             res_kind;
	logic [31:0]            res_blk;

	logic       crc_ok;
	logic       arg_oor;
	logic       next_oor;
	logic       beat_out;
	logic       out_free;
	logic       advance;
	logic [6:0] crc_calc;

	// Handshakes: the decode hands on when the result line is free or the
	// event gives no result.
	assign cfg_ready = 1'b1;
	assign beat_out  = m_tvalid && m_tready;
	assign out_free  = !m_tvalid || (beat_out && m_tlast);
	assign advance   = valid_s1 && (out_free || (res_n == 3'd0));
	assign s_tready  = !valid_s1 || advance;

	// Output beat.
	assign m_tvalid = (rem_q != 3'd0);
	assign m_tlast  = (rem_q == 3'd1);
	assign m_tdata  = {blk_q, bytes_q[0]};
	assign m_tuser  = kind_q;

	// Frame check and range checks.
	assign crc_calc = sdspi_pkg::crc7_parallel({sdspi_pkg::START_BITS[7:6], cmd_s1, arg_s1});
	assign crc_ok   = (crc_s1 == {crc_calc, 1'b1});
	assign arg_oor  = (arg_s1 >= block_capacity_q) || (arg_s1 > sdspi_pkg::ADDR_MASK);
	assign next_oor = (next_block_q >= block_capacity_q) ||
	                  (next_block_q > sdspi_pkg::ADDR_MASK);

	// Event decode: results and next card state.
	always_comb begin
		mode_d       = mode_q;
		status_d     = status_q;
		app_pend_d   = app_pend_q;
		blocks_rem_d = blocks_rem_q;
		next_block_d = next_block_q;
		crc_en_d     = crc_en_q;
		host_hc_d    = host_hc_q;
		res_n        = 3'd0;
		res_bytes    = '0;
		res_kind     = sdspi_pkg::KIND_BYTE;
		res_blk      = 32'd0;
		case (op_s1)
			sdspi_pkg::OP_COMMAND: begin
				// A bad frame during a transfer is dropped without a reply.
				if (crc_ok || (mode_q == sdspi_pkg::XFER_IDLE)) begin
					res_bytes[0] = sdspi_pkg::FILL_BYTE;
					res_bytes[1] = sdspi_pkg::FILL_BYTE;
					res_n        = 3'd3;
					if (!crc_ok) begin
						res_bytes[2] = sdspi_pkg::R1_CRC_ERR;
					end else if (app_pend_q) begin
						app_pend_d = 1'b0;
						case (cmd_s1)
							sdspi_pkg::ACMD_SET_WR_ERASE: begin
								status_d     = sdspi_pkg::ST_WP_VIOLATION |
								               sdspi_pkg::ST_WRITE_PROT;
								res_bytes[2] = sdspi_pkg::R1_ERASE_CLR;
							end
							sdspi_pkg::ACMD_SEND_OP_COND: begin
								status_d     = sdspi_pkg::ST_READY;
								host_hc_d    = arg_s1[30];
								res_bytes[2] = sdspi_pkg::R1_READY;
							end
							default: begin
								res_bytes[2] = sdspi_pkg::R1_ILLEGAL;
							end
						endcase
					end else begin
						case (cmd_s1) inside
							sdspi_pkg::CMD_GO_IDLE: begin
								status_d     = sdspi_pkg::ST_READY;
								res_bytes[2] = sdspi_pkg::R1_IDLE;
							end
							sdspi_pkg::CMD_SEND_IF_COND: begin
								status_d     = sdspi_pkg::ST_READY;
								res_bytes[2] = sdspi_pkg::R1_READY;
								res_bytes[3] = 8'h00;
								res_bytes[4] = 8'h00;
								res_bytes[5] = sdspi_pkg::IF_COND_BYTE;
								res_bytes[6] = arg_s1[7:0];
								res_n        = 3'd7;
							end
							sdspi_pkg::CMD_SEND_CSD, sdspi_pkg::CMD_SEND_CID: begin
								mode_d       = (cmd_s1 == sdspi_pkg::CMD_SEND_CSD) ?
								               sdspi_pkg::XFER_CSD : sdspi_pkg::XFER_CID;
								blocks_rem_d = 32'd0;
								status_d     = sdspi_pkg::ST_READY;
								res_bytes[2] = sdspi_pkg::R1_READY;
							end
							sdspi_pkg::CMD_STOP: begin
								mode_d       = sdspi_pkg::XFER_IDLE;
								blocks_rem_d = 32'd0;
								status_d     = sdspi_pkg::ST_READY;
								res_bytes[2] = sdspi_pkg::R1_READY;
							end
							sdspi_pkg::CMD_SEND_STATUS: begin
								res_bytes[2] = sdspi_pkg::R1_READY;
								res_bytes[3] = status_q;
								res_n        = 3'd4;
							end
							sdspi_pkg::CMD_READ_SINGLE, sdspi_pkg::CMD_READ_MULTI: begin
								next_block_d = arg_s1;
								if (arg_oor) begin
									mode_d       = sdspi_pkg::XFER_IDLE;
									blocks_rem_d = 32'd0;
									status_d     = sdspi_pkg::ST_OUT_OF_RANGE;
									res_bytes[2] = sdspi_pkg::R1_PARAM_ERR;
								end else begin
									mode_d       = sdspi_pkg::XFER_BLOCK;
									blocks_rem_d = (cmd_s1 == sdspi_pkg::CMD_READ_SINGLE) ?
									               32'd1 : 32'hffffffff;
									status_d     = sdspi_pkg::ST_READY;
									res_bytes[2] = sdspi_pkg::R1_READY;
								end
							end
							sdspi_pkg::CMD_WRITE_SINGLE, sdspi_pkg::CMD_WRITE_MULTI,
							sdspi_pkg::CMD_ERASE_START, sdspi_pkg::CMD_ERASE_END,
							sdspi_pkg::CMD_ERASE: begin
								status_d     = sdspi_pkg::ST_WP_VIOLATION |
								               sdspi_pkg::ST_WRITE_PROT;
								res_bytes[2] = sdspi_pkg::R1_ERASE_CLR;
							end
							sdspi_pkg::CMD_APP_CMD: begin
								app_pend_d   = 1'b1;
								res_bytes[2] = sdspi_pkg::R1_READY;
							end
							sdspi_pkg::CMD_READ_OCR: begin
								res_bytes[2] = sdspi_pkg::R1_READY;
								res_bytes[3] = sdspi_pkg::OCR_VALUE[31:24];
								res_bytes[4] = sdspi_pkg::OCR_VALUE[23:16];
								res_bytes[5] = sdspi_pkg::OCR_VALUE[15:8];
								res_bytes[6] = sdspi_pkg::OCR_VALUE[7:0];
								res_n        = 3'd7;
							end
							sdspi_pkg::CMD_CRC_ON_OFF: begin
								crc_en_d     = (arg_s1 != 32'd0);
								res_bytes[2] = sdspi_pkg::R1_READY;
							end
							default: begin
								res_bytes[2] = sdspi_pkg::R1_ILLEGAL;
							end
						endcase
					end
				end
			end
			sdspi_pkg::OP_DATA_SLOT: begin
				case (mode_q)
					sdspi_pkg::XFER_CID, sdspi_pkg::XFER_CSD: begin
						res_n    = 3'd1;
						res_kind = (mode_q == sdspi_pkg::XFER_CID) ?
						           sdspi_pkg::KIND_SEND_CID : sdspi_pkg::KIND_SEND_CSD;
						mode_d   = sdspi_pkg::XFER_IDLE;
					end
					sdspi_pkg::XFER_BLOCK: begin
						if (blocks_rem_q != 32'd0) begin
							blocks_rem_d = blocks_rem_q - 32'd1;
							if (next_oor) begin
								// A read that runs off the card stops without a beat.
								status_d     = sdspi_pkg::ST_OUT_OF_RANGE;
								blocks_rem_d = 32'd0;
								mode_d       = sdspi_pkg::XFER_IDLE;
							end else begin
								status_d     = sdspi_pkg::ST_READY;
								res_n        = 3'd1;
								res_kind     = sdspi_pkg::KIND_FETCH;
								res_blk      = next_block_q;
								next_block_d = (next_block_q + 32'd1) & sdspi_pkg::ADDR_MASK;
							end
						end else begin
							mode_d = sdspi_pkg::XFER_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			sdspi_pkg::OP_READ_FAIL: begin
				status_d     = sdspi_pkg::ST_ERROR;
				blocks_rem_d = 32'd0;
				mode_d       = sdspi_pkg::XFER_IDLE;
			end
			default: begin
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_capacity_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			block_capacity_q <= cfg_data;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			cmd_s1 <= s_tdata[5:0];
			arg_s1 <= s_tdata[37:6];
			crc_s1 <= s_tdata[45:38];
		end
	end

	// Card state update, one event per hand-on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= sdspi_pkg::XFER_IDLE;
			status_q     <= sdspi_pkg::ST_READY;
			app_pend_q   <= 1'b0;
			blocks_rem_q <= 32'd0;
			next_block_q <= 32'd0;
			crc_en_q     <= 1'b0;
			host_hc_q    <= 1'b0;
		end else if (advance) begin
			mode_q       <= mode_d;
			status_q     <= status_d;
			app_pend_q   <= app_pend_d;
			blocks_rem_q <= blocks_rem_d;
			next_block_q <= next_block_d;
			crc_en_q     <= crc_en_d;
			host_hc_q    <= host_hc_d;
		end
	end

	// Result line count: load a fresh burst or count down per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (advance && (res_n != 3'd0)) begin
			rem_q <= res_n;
		end else if (beat_out) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// Result line payload: the current byte always sits at the bottom.
	always_ff @(posedge clk) begin
		if (advance && (res_n != 3'd0)) begin
			bytes_q <= res_bytes;
			kind_q  <= res_kind;
			blk_q   <= res_blk;
		end else if (beat_out) begin
			bytes_q <= {8'h00, bytes_q[sdspi_pkg::RESP_MAX-1:1]};
		end
	end

endmodule

// ===== tb/sd_spi_command_responder_tb.sv =====
// Self-checking testbench for the SD SPI-mode command responder.
// Drives command, data-slot and failure beats, predicts each response in a
// behavioral card model, and checks every output beat. Depends on sdspi_pkg.
module sd_spi_command_responder_tb;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         SETTLE_CYCLES  = 12;
	localparam int         MAX_PRINTED    = 40;

	// Commands that take no follow-up beats, for the random part.
	localparam logic [5:0] PLAIN_CMDS [12] = '{
		sdspi_pkg::CMD_GO_IDLE, sdspi_pkg::CMD_SEND_IF_COND, sdspi_pkg::CMD_STOP,
		sdspi_pkg::CMD_SEND_STATUS, sdspi_pkg::CMD_WRITE_SINGLE, sdspi_pkg::CMD_WRITE_MULTI,
		sdspi_pkg::CMD_ERASE_START, sdspi_pkg::CMD_ERASE_END, sdspi_pkg::CMD_ERASE,
		sdspi_pkg::CMD_APP_CMD, sdspi_pkg::CMD_READ_OCR, sdspi_pkg::CMD_CRC_ON_OFF
	};

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  index;
		logic [31:0] arg;
		logic [7:0]  crc;
	} card_event_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [31:0] block;
		logic        last;
	} card_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = 48'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	sd_spi_command_responder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Card state as the predictor sees it.
	sdspi_pkg::mode_t xfer_mode = sdspi_pkg::XFER_IDLE;
	logic [7:0]  card_status = sdspi_pkg::ST_READY;
	logic        app_pending = 1'b0;
	logic [31:0] blocks_left = 32'd0;
	logic [31:0] next_blk = 32'd0;
	logic        crc_on = 1'b0;
	logic        host_hc = 1'b0;
	logic [31:0] card_capacity = 32'd0;

	card_event_t pending_events [$];
	card_beat_t  expected_beats [$];
	card_event_t offered_event;
	int unsigned queued_count = 0;
	int unsigned fail_count = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	logic        rx_hold = 1'b0;
	int          phase_id = 0;
	int unsigned quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTED) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		fail_count++;
	endtask

	// CRC7 over the 40-bit frame body: start bits, index and argument.
	function automatic logic [6:0] frame_crc7(input logic [5:0] index, input logic [31:0] arg);
		logic [39:0] body;
		logic [6:0]  crc;
		logic        fb;
		body = {sdspi_pkg::START_BITS[7:6], index, arg};
		crc = 7'd0;
		for (int b = 39; b >= 0; b--) begin
			fb = body[b] ^ crc[6];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ 7'h09;
			end
		end
		return crc;
	endfunction

	function automatic logic beyond_card(input logic [31:0] blk);
		return blk >= card_capacity || blk > sdspi_pkg::ADDR_MASK;
	endfunction

	// Applies one accepted beat to the card state and queues the beats it answers with.
	function automatic void predict_card_response(input card_event_t ev);
		logic [7:0] line [$];
		logic       good;
		good = ev.crc == {frame_crc7(ev.index, ev.arg), 1'b1};
		case (ev.opcode)
		sdspi_pkg::OP_COMMAND: begin
			// A corrupted frame in the middle of a transfer is dropped silently.
			if (!good && xfer_mode != sdspi_pkg::XFER_IDLE) begin
				return;
			end
			line = '{sdspi_pkg::FILL_BYTE, sdspi_pkg::FILL_BYTE};
			if (!good) begin
				line.push_back(sdspi_pkg::R1_CRC_ERR);
			end else if (app_pending) begin
				app_pending = 1'b0;
				if (ev.index == sdspi_pkg::ACMD_SET_WR_ERASE) begin
					card_status = sdspi_pkg::ST_WP_VIOLATION | sdspi_pkg::ST_WRITE_PROT;
					line.push_back(sdspi_pkg::R1_ERASE_CLR);
				end else if (ev.index == sdspi_pkg::ACMD_SEND_OP_COND) begin
					card_status = sdspi_pkg::ST_READY;
					host_hc = ev.arg[30];
					line.push_back(sdspi_pkg::R1_READY);
				end else begin
					line.push_back(sdspi_pkg::R1_ILLEGAL);
				end
			end else begin
				case (ev.index)
				sdspi_pkg::CMD_GO_IDLE: begin
					card_status = sdspi_pkg::ST_READY;
					line.push_back(sdspi_pkg::R1_IDLE);
				end
				sdspi_pkg::CMD_SEND_IF_COND: begin
					card_status = sdspi_pkg::ST_READY;
					line.push_back(sdspi_pkg::R1_READY);
					line.push_back(8'h00);
					line.push_back(8'h00);
					line.push_back(sdspi_pkg::IF_COND_BYTE);
					line.push_back(ev.arg[7:0]);
				end
				sdspi_pkg::CMD_SEND_CSD, sdspi_pkg::CMD_SEND_CID: begin
					xfer_mode = (ev.index == sdspi_pkg::CMD_SEND_CSD) ?
						sdspi_pkg::XFER_CSD : sdspi_pkg::XFER_CID;
					blocks_left = 32'd0;
					card_status = sdspi_pkg::ST_READY;
					line.push_back(sdspi_pkg::R1_READY);
				end
				sdspi_pkg::CMD_STOP: begin
					xfer_mode = sdspi_pkg::XFER_IDLE;
					blocks_left = 32'd0;
					card_status = sdspi_pkg::ST_READY;
					line.push_back(sdspi_pkg::R1_READY);
				end
				sdspi_pkg::CMD_SEND_STATUS: begin
					line.push_back(sdspi_pkg::R1_READY);
					line.push_back(card_status);
				end
				sdspi_pkg::CMD_READ_SINGLE, sdspi_pkg::CMD_READ_MULTI: begin
					next_blk = ev.arg;
					if (beyond_card(ev.arg)) begin
						xfer_mode = sdspi_pkg::XFER_IDLE;
						blocks_left = 32'd0;
						card_status = sdspi_pkg::ST_OUT_OF_RANGE;
						line.push_back(sdspi_pkg::R1_PARAM_ERR);
					end else begin
						xfer_mode = sdspi_pkg::XFER_BLOCK;
						blocks_left = (ev.index == sdspi_pkg::CMD_READ_SINGLE) ?
							32'd1 : 32'hffff_ffff;
						card_status = sdspi_pkg::ST_READY;
						line.push_back(sdspi_pkg::R1_READY);
					end
				end
				sdspi_pkg::CMD_WRITE_SINGLE, sdspi_pkg::CMD_WRITE_MULTI,
				sdspi_pkg::CMD_ERASE_START, sdspi_pkg::CMD_ERASE_END,
				sdspi_pkg::CMD_ERASE: begin
					card_status = sdspi_pkg::ST_WP_VIOLATION | sdspi_pkg::ST_WRITE_PROT;
					line.push_back(sdspi_pkg::R1_ERASE_CLR);
				end
				sdspi_pkg::CMD_APP_CMD: begin
					app_pending = 1'b1;
					line.push_back(sdspi_pkg::R1_READY);
				end
				sdspi_pkg::CMD_READ_OCR: begin
					line.push_back(sdspi_pkg::R1_READY);
					line.push_back(sdspi_pkg::OCR_VALUE[31:24]);
					line.push_back(sdspi_pkg::OCR_VALUE[23:16]);
					line.push_back(sdspi_pkg::OCR_VALUE[15:8]);
					line.push_back(sdspi_pkg::OCR_VALUE[7:0]);
				end
				sdspi_pkg::CMD_CRC_ON_OFF: begin
					crc_on = ev.arg != 32'd0;
					line.push_back(sdspi_pkg::R1_READY);
				end
				default: begin
					line.push_back(sdspi_pkg::R1_ILLEGAL);
				end
				endcase
			end
			foreach (line[i]) begin
				expected_beats.push_back('{sdspi_pkg::KIND_BYTE, line[i], 32'd0,
					1'(i == line.size() - 1)});
			end
		end
		sdspi_pkg::OP_DATA_SLOT: begin
			if (xfer_mode == sdspi_pkg::XFER_CID || xfer_mode == sdspi_pkg::XFER_CSD) begin
				expected_beats.push_back('{(xfer_mode == sdspi_pkg::XFER_CID) ?
					sdspi_pkg::KIND_SEND_CID : sdspi_pkg::KIND_SEND_CSD,
					8'd0, 32'd0, 1'b1});
				xfer_mode = sdspi_pkg::XFER_IDLE;
			end else if (xfer_mode == sdspi_pkg::XFER_BLOCK) begin
				if (blocks_left != 32'd0) begin
					blocks_left--;
					// A multi-block read running past the card ends without a beat.
					if (beyond_card(next_blk)) begin
						card_status = sdspi_pkg::ST_OUT_OF_RANGE;
						blocks_left = 32'd0;
						xfer_mode = sdspi_pkg::XFER_IDLE;
					end else begin
						card_status = sdspi_pkg::ST_READY;
						expected_beats.push_back('{sdspi_pkg::KIND_FETCH, 8'd0, next_blk, 1'b1});
						next_blk = (next_blk + 32'd1) & sdspi_pkg::ADDR_MASK;
					end
				end else begin
					xfer_mode = sdspi_pkg::XFER_IDLE;
				end
			end
		end
		sdspi_pkg::OP_READ_FAIL: begin
			card_status = sdspi_pkg::ST_ERROR;
			blocks_left = 32'd0;
			xfer_mode = sdspi_pkg::XFER_IDLE;
		end
		default: begin
		end
		endcase
	endfunction

	// Wait before the next beat; calm stretches with no waiting come and go.
	function automatic int unsigned next_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// Input driver: offers queued events, predicting each one as it is accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_card_response(offered_event);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					offered_event = pending_events.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= offered_event.opcode;
					s_tdata <= {2'b00, offered_event.crc, offered_event.arg, offered_event.index};
					tx_wait = next_wait(tx_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random stalls between beats, plus the long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				rx_wait = next_wait(rx_calm);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0) && !rx_hold;
		end
	end

	// Output monitor: every beat must match the oldest outstanding prediction.
	always @(posedge clk) begin
		card_beat_t got;
		card_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[7:0], m_tdata[39:8], m_tlast};
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat kind %0d data %02h block %08h",
					got.kind, got.data, got.block));
			end else begin
				want = expected_beats.pop_front();
				if (got.kind != want.kind) begin
					report_mismatch($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
				end
				if (got.data != want.data) begin
					report_mismatch($sformatf("data byte %02h, predicted %02h", got.data, want.data));
				end
				if (got.block != want.block) begin
					report_mismatch($sformatf("block %08h, predicted %08h", got.block, want.block));
				end
				if (got.last != want.last) begin
					report_mismatch($sformatf("tlast %0b, predicted %0b", got.last, want.last));
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Long receiver hold-off during the third phase, so the input backs up.
	initial begin
		while (phase_id != 3) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (350) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic card_event_t cmd_frame(input logic [5:0] index, input logic [31:0] arg);
		return '{sdspi_pkg::OP_COMMAND, index, arg, {frame_crc7(index, arg), 1'b1}};
	endfunction

	function automatic card_event_t bad_frame(input logic [5:0] index, input logic [31:0] arg);
		card_event_t ev;
		ev = cmd_frame(index, arg);
		ev.crc = ev.crc ^ 8'($urandom_range(1, 255));
		return ev;
	endfunction

	function automatic card_event_t side_event(input logic [1:0] opcode);
		return '{opcode, 6'($urandom), 32'($urandom), 8'($urandom)};
	endfunction

	task automatic queue_event(input card_event_t ev);
		pending_events.push_back(ev);
		if (ev.opcode != OP_UNUSED) begin
			queued_count++;
		end
	endtask

	// Block addresses cluster around the capacity edge.
	function automatic logic [31:0] pick_block();
		case ($urandom_range(0, 5))
		0: return (card_capacity == 32'd0) ? 32'd0 : $urandom_range(card_capacity - 32'd1, 0);
		1: return card_capacity - $urandom_range(1, 3);
		2: return card_capacity;
		3: return card_capacity + $urandom_range(0, 3);
		4: return $urandom;
		default: return $urandom_range(0, 7);
		endcase
	endfunction

	// One random command sequence, mostly well formed.
	task automatic append_random_sequence();
		int unsigned pick;
		int unsigned slots;
		logic [5:0]  idx;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			idx = $urandom_range(0, 1) ? sdspi_pkg::CMD_READ_MULTI : sdspi_pkg::CMD_READ_SINGLE;
			queue_event(cmd_frame(idx, pick_block()));
			slots = $urandom_range(0, 6);
			repeat (slots) begin
				if ($urandom_range(0, 7) == 0) begin
					queue_event(bad_frame(6'($urandom), $urandom));
				end else begin
					queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
				end
			end
			case ($urandom_range(0, 3))
			0: queue_event(cmd_frame(sdspi_pkg::CMD_STOP, $urandom));
			1: queue_event(side_event(sdspi_pkg::OP_READ_FAIL));
			default: begin
			end
			endcase
		end else if (pick < 45) begin
			idx = $urandom_range(0, 1) ? sdspi_pkg::CMD_SEND_CID : sdspi_pkg::CMD_SEND_CSD;
			queue_event(cmd_frame(idx, $urandom));
			if ($urandom_range(0, 3) == 0) begin
				queue_event(bad_frame(6'($urandom), $urandom));
			end
			queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
			if ($urandom_range(0, 2) == 0) begin
				queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
			end
		end else if (pick < 60) begin
			queue_event(cmd_frame(sdspi_pkg::CMD_APP_CMD, $urandom));
			case ($urandom_range(0, 2))
			0: idx = sdspi_pkg::ACMD_SET_WR_ERASE;
			1: idx = sdspi_pkg::ACMD_SEND_OP_COND;
			default: idx = 6'($urandom);
			endcase
			queue_event(cmd_frame(idx, $urandom));
		end else if (pick < 80) begin
			queue_event(cmd_frame(PLAIN_CMDS[$urandom_range(0, 11)], $urandom));
		end else if (pick < 88) begin
			queue_event(cmd_frame(6'($urandom), $urandom));
		end else if (pick < 94) begin
			queue_event(bad_frame(6'($urandom), $urandom));
		end else begin
			queue_event(side_event(2'($urandom)));
		end
	endtask

	task automatic queue_random_phase(input int unsigned target);
		queued_count = 0;
		while (queued_count < target) begin
			append_random_sequence();
		end
	endtask

	// Directed part, run with a capacity of 20 blocks.
	task automatic queue_directed_events();
		queue_event(cmd_frame(sdspi_pkg::CMD_GO_IDLE, 32'd0));
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_IF_COND, 32'h0000_01aa));
		queue_event(cmd_frame(sdspi_pkg::CMD_READ_OCR, 32'hffff_ffff));
		// Application commands: capacity handshake, refused write setting, unknown one.
		queue_event(cmd_frame(sdspi_pkg::CMD_APP_CMD, 32'd0));
		queue_event(cmd_frame(sdspi_pkg::ACMD_SEND_OP_COND, 32'h4000_0000));
		queue_event(cmd_frame(sdspi_pkg::CMD_APP_CMD, 32'd0));
		queue_event(cmd_frame(sdspi_pkg::ACMD_SET_WR_ERASE, 32'd1));
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_STATUS, 32'd0));
		queue_event(cmd_frame(sdspi_pkg::CMD_APP_CMD, 32'd0));
		queue_event(cmd_frame(6'd63, 32'd0));
		queue_event(cmd_frame(6'd63, 32'hffff_ffff));
		queue_event('{sdspi_pkg::OP_COMMAND, sdspi_pkg::CMD_GO_IDLE, 32'd0, 8'h00});
		queue_event(cmd_frame(sdspi_pkg::CMD_ERASE, 32'd0));
		// Single reads: one past the end, then the last block and the slots after it.
		queue_event(cmd_frame(sdspi_pkg::CMD_READ_SINGLE, 32'd20));
		queue_event(cmd_frame(sdspi_pkg::CMD_READ_SINGLE, 32'd19));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_CID, 32'd0));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		// Multi-block read that runs off the end, with a corrupted frame inside it.
		queue_event(cmd_frame(sdspi_pkg::CMD_READ_MULTI, 32'd18));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event('{sdspi_pkg::OP_COMMAND, sdspi_pkg::CMD_STOP, 32'd0, 8'hff});
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_STATUS, 32'd0));
		// Storage failure in the middle of a register send.
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_CSD, 32'd0));
		queue_event(side_event(sdspi_pkg::OP_READ_FAIL));
		queue_event('{OP_UNUSED, 6'd63, 32'hffff_ffff, 8'hff});
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_STATUS, 32'd0));
	endtask

	task automatic write_capacity(input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		card_capacity = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_events.size() != 0 || s_tvalid || expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Phases with different capacities, each started once the previous one has drained.
	initial begin
		while (!arst_n) begin
			@(posedge clk);
		end
		phase_id = 1;
		write_capacity(32'd20);
		queue_directed_events();
		wait_idle();

		phase_id = 2;
		write_capacity(32'd0);
		queue_random_phase(50);
		wait_idle();

		phase_id = 3;
		write_capacity(32'hffff_ffff);
		queue_event(cmd_frame(sdspi_pkg::CMD_READ_MULTI, 32'hffff_fffe));
		repeat (3) queue_event(side_event(sdspi_pkg::OP_DATA_SLOT));
		queue_event(cmd_frame(sdspi_pkg::CMD_SEND_STATUS, 32'd0));
		queue_random_phase(110);
		wait_idle();

		phase_id = 4;
		write_capacity($urandom_range(1, 64));
		queue_random_phase(175);
		wait_idle();

		repeat (20) @(posedge clk);
		if (expected_beats.size() != 0) begin
			report_mismatch($sformatf("%0d predicted beats never arrived", expected_beats.size()));
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sdspi_pkg.sv
sv/sd_spi_command_responder.sv
tb/sd_spi_command_responder_tb.sv
